>>> design/bpt_pkg.sv
// Shared types and constants for the batch phase tracker.
`default_nettype none

package bpt_pkg;

   // Screen type codes of interest
   localparam logic [7:0] FT_IDLE       = 8'd1;
   localparam logic [7:0] FT_TRANSITION = 8'd2;
   localparam logic [7:0] FT_FREEZE     = 8'd4;
   localparam logic [7:0] FT_DRY        = 8'd5;
   localparam logic [7:0] FT_FINAL      = 8'd6;
   localparam logic [7:0] FT_DONE       = 8'd7;
   localparam logic [7:0] FT_PURGE      = 8'd8;
   localparam logic [7:0] FT_DEFROST    = 8'd9;
   localparam logic [7:0] FT_DEFROST_DN = 8'd10;
   localparam logic [7:0] FT_DIAG       = 8'd15;
   localparam logic [7:0] FT_PREP       = 8'd17;
   localparam logic [7:0] FT_RECIPE     = 8'd31;
   localparam logic [7:0] FT_FINAL_ALT  = 8'd44;

   // Phase codes
   localparam logic [3:0] PH_UNKNOWN    = 4'd0;
   localparam logic [3:0] PH_IDLE       = 4'd1;
   localparam logic [3:0] PH_PREP       = 4'd2;
   localparam logic [3:0] PH_TRANSITION = 4'd3;
   localparam logic [3:0] PH_RUNNING    = 4'd4;
   localparam logic [3:0] PH_DIAG       = 4'd5;
   localparam logic [3:0] PH_RECIPE     = 4'd6;
   localparam logic [3:0] PH_FREEZE     = 4'd7;
   localparam logic [3:0] PH_DRY        = 4'd8;
   localparam logic [3:0] PH_FINAL      = 4'd9;
   localparam logic [3:0] PH_DONE       = 4'd10;
   localparam logic [3:0] PH_PURGE      = 4'd11;
   localparam logic [3:0] PH_DEFROST    = 4'd12;
   localparam logic [3:0] PH_DEFROST_DN = 4'd13;

   localparam logic [0:0]  CMD_TICK        = 1'b1;
   localparam logic [7:0]  PCT_FULL        = 8'd100;
   localparam logic [31:0] STALE_RESET     = 32'd60000;

   // Front-to-back queue
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Serial divider: (dt * remaining) / dpct, 32 x 7 bit product, 8 bit divisor
   localparam int DIV_DIVIDEND_W = 39;
   localparam int DIV_DIVISOR_W  = 8;
   localparam int DIV_CNT_W      = 6;
   localparam logic [DIV_CNT_W-1:0] DIV_STEPS = DIV_CNT_W'(DIV_DIVIDEND_W);

   typedef enum logic [2:0] {
      KIND_TICK,
      KIND_PREP,
      KIND_PURGE,
      KIND_FREEZE,
      KIND_IDLE_SCREEN,
      KIND_OTHER
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [3:0]  phase;
      logic [31:0] elapsed;
      logic [7:0]  pct;
      logic [31:0] now;
   } item_type;

   typedef struct packed {
      logic                      start;
      logic [DIV_DIVIDEND_W-1:0] dividend;
      logic [DIV_DIVISOR_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic                      done;
      logic [DIV_DIVIDEND_W-1:0] quotient;
   } div_rsp_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_READ,
      ST_DIFF,
      ST_MUL,
      ST_DIV,
      ST_OUT
   } back_state_type;

endpackage

`default_nettype wire

>>> design/batch_phase_tracker_with_eta_top.sv
// Top level of the batch phase tracker with freeze ETA.
// Sequence: an item is popped in ST_IDLE, passes ST_UPDATE and ends in ST_OUT for
//   ticks, non-freeze frames and freeze frames at full percent; other freeze frames
//   also pass ST_READ and ST_DIFF, and a freeze estimate ST_MUL and ST_DIV (the
//   39-step serial divider); ST_OUT waits out rsp_stall, then registers rsp_valid.
// The back end works one item at a time; the two-entry queue keeps filling.
// Reset (synchronous, active high) clears run state and queue, sets the stale
//   timeout to 60000 ms; the window memory is not cleared.
`default_nettype none

module batch_phase_tracker_with_eta_top #(
   parameter int RATE_WINDOW = 8   // freeze rate window depth, 2..64
) (
   input  wire         clock,
   input  wire         reset,
   // request items
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [0:0]  req_command,
   input  wire  [7:0]  req_frame_type,
   input  wire  [31:0] req_batch_elapsed_s,
   input  wire  [7:0]  req_progress_pct,
   input  wire  [31:0] req_now_ms,
   // result items
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [3:0]  rsp_phase_code,
   output logic [0:0]  rsp_run_active,
   output logic [0:0]  rsp_eta_valid,
   output logic [31:0] rsp_eta_s,
   // stale timeout register
   input  wire         csr_wr_en,
   input  wire  [31:0] csr_wr_data
);
   import bpt_pkg::*;

   queue_status_type q_status;
   item_type         push_item;
   item_type         pop_item;
   logic             push;
   logic             pop;
   div_req_type      div_req;
   div_rsp_type      div_rsp;

   // Front end: classify the screen type, push into the queue
   bpt_front u_front (
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_command         (req_command),
      .req_frame_type      (req_frame_type),
      .req_batch_elapsed_s (req_batch_elapsed_s),
      .req_progress_pct    (req_progress_pct),
      .req_now_ms          (req_now_ms),
      .q_status            (q_status),
      .push                (push),
      .push_item           (push_item)
   );

   // Decouples the front end from the slow estimate path
   bpt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .q_status  (q_status)
   );

   // ETA = dt * remaining / dpct, one quotient bit per cycle
   bpt_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Back end: run logic, percent window, estimate, result register
   bpt_back #(
      .RATE_WINDOW (RATE_WINDOW)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .q_status       (q_status),
      .pop_item       (pop_item),
      .pop            (pop),
      .div_req        (div_req),
      .div_rsp        (div_rsp),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_phase_code (rsp_phase_code),
      .rsp_run_active (rsp_run_active),
      .rsp_eta_valid  (rsp_eta_valid),
      .rsp_eta_s      (rsp_eta_s)
   );

endmodule

`default_nettype wire

>>> design/bpt_front.sv
// Front end: takes request items and classifies the screen type.
`default_nettype none

module bpt_front (
   input  wire                       req_valid,
   output logic                      req_stall,
   input  wire  [0:0]                req_command,
   input  wire  [7:0]                req_frame_type,
   input  wire  [31:0]               req_batch_elapsed_s,
   input  wire  [7:0]                req_progress_pct,
   input  wire  [31:0]               req_now_ms,
   input  bpt_pkg::queue_status_type q_status,
   output logic                      push,
   output bpt_pkg::item_type         push_item
);
   import bpt_pkg::*;

   kind_type   kind;
   logic [3:0] phase;

   always_comb begin
      kind  = KIND_OTHER;
      phase = PH_UNKNOWN;
      if (req_command == CMD_TICK) begin
         kind = KIND_TICK;
      end else begin
         case (req_frame_type)
            FT_PREP:       begin kind = KIND_PREP;        phase = PH_PREP;       end
            FT_FREEZE:     begin kind = KIND_FREEZE;      phase = PH_FREEZE;     end
            FT_DRY:        phase = PH_DRY;
            FT_FINAL:      phase = PH_FINAL;
            FT_FINAL_ALT:  phase = PH_FINAL;
            FT_DONE:       phase = PH_DONE;
            FT_PURGE:      begin kind = KIND_PURGE;       phase = PH_PURGE;      end
            FT_DEFROST:    phase = PH_DEFROST;
            FT_DEFROST_DN: phase = PH_DEFROST_DN;
            FT_TRANSITION: phase = PH_TRANSITION;
            FT_DIAG:       phase = PH_DIAG;
            FT_RECIPE:     phase = PH_RECIPE;
            FT_IDLE:       begin kind = KIND_IDLE_SCREEN; phase = PH_IDLE;       end
            default:       phase = PH_UNKNOWN;
         endcase
      end
   end

   assign req_stall         = q_status.full;
   assign push              = req_valid && !q_status.full;
   assign push_item.kind    = kind;
   assign push_item.phase   = phase;
   assign push_item.elapsed = req_batch_elapsed_s;
   assign push_item.pct     = req_progress_pct;
   assign push_item.now     = req_now_ms;

endmodule

`default_nettype wire

>>> design/bpt_queue.sv
// Short item queue between front end and back end.
`default_nettype none

module bpt_queue (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        push,
   input  bpt_pkg::item_type          push_item,
   input  wire                        pop,
   output bpt_pkg::item_type          pop_item,
   output bpt_pkg::queue_status_type  q_status
);
   import bpt_pkg::*;

   item_type                 slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff, count_in;
   logic                     do_push, do_pop;

   localparam logic [QUEUE_CNT_W-1:0] CNT_FULL = QUEUE_CNT_W'(QUEUE_DEPTH);
   localparam logic [QUEUE_PTR_W-1:0] PTR_LAST = QUEUE_PTR_W'(QUEUE_DEPTH - 1);

   assign q_status.full  = (count_ff == CNT_FULL);
   assign q_status.empty = (count_ff == '0);
   assign do_push = push && !q_status.full;
   assign do_pop  = pop && !q_status.empty;
   assign pop_item = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

>>> design/bpt_divider.sv
// Restoring serial divider, one quotient bit per cycle.
`default_nettype none

module bpt_divider (
   input  wire                  clock,
   input  wire                  reset,
   input  bpt_pkg::div_req_type div_req,
   output bpt_pkg::div_rsp_type div_rsp
);
   import bpt_pkg::*;

   logic                      busy_ff;
   logic                      done_ff;
   logic [DIV_CNT_W-1:0]      cnt_ff;
   logic [DIV_DIVISOR_W-1:0]  rem_ff;
   logic [DIV_DIVISOR_W-1:0]  divisor_ff;
   logic [DIV_DIVIDEND_W-1:0] quo_ff;
   logic [DIV_DIVISOR_W:0]    trial;
   logic                      fits;
   logic [DIV_DIVISOR_W:0]    trial_sub;

   // rem < divisor, so the shifted trial stays under twice the divisor
   assign trial     = {rem_ff, quo_ff[DIV_DIVIDEND_W-1]};
   assign fits      = (trial >= {1'b0, divisor_ff});
   assign trial_sub = trial - {1'b0, divisor_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= DIV_STEPS;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == DIV_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         quo_ff     <= div_req.dividend;
         rem_ff     <= '0;
         divisor_ff <= div_req.divisor;
      end else if (busy_ff) begin
         rem_ff <= fits ? trial_sub[DIV_DIVISOR_W-1:0] : trial[DIV_DIVISOR_W-1:0];
         quo_ff <= {quo_ff[DIV_DIVIDEND_W-2:0], fits};
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

`default_nettype wire

>>> design/bpt_back.sv
// Back end: run tracking, freeze window, estimate sequencer and result register.
`default_nettype none

module bpt_back #(
   parameter int RATE_WINDOW = 8
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        csr_wr_en,
   input  wire  [31:0]                csr_wr_data,
   input  bpt_pkg::queue_status_type  q_status,
   input  bpt_pkg::item_type          pop_item,
   output logic                       pop,
   output bpt_pkg::div_req_type       div_req,
   input  bpt_pkg::div_rsp_type       div_rsp,
   output logic                       rsp_valid,
   input  wire                        rsp_stall,
   output logic [3:0]                 rsp_phase_code,
   output logic [0:0]                 rsp_run_active,
   output logic [0:0]                 rsp_eta_valid,
   output logic [31:0]                rsp_eta_s
);
   import bpt_pkg::*;

   localparam int HEAD_W = (RATE_WINDOW > 1) ? $clog2(RATE_WINDOW) : 1;
   localparam int FILL_W = $clog2(RATE_WINDOW + 1);
   localparam logic [HEAD_W-1:0] HEAD_LAST = HEAD_W'(RATE_WINDOW - 1);
   localparam logic [FILL_W-1:0] FILL_MAX  = FILL_W'(RATE_WINDOW);
   localparam logic [FILL_W:0]   WIN_EXT   = (FILL_W + 1)'(RATE_WINDOW);
   localparam logic [FILL_W-1:0] FILL_TWO  = FILL_W'(2);

   back_state_type state_ff, state_in;

   logic [31:0]       timeout_ff;
   item_type          item_ff;
   logic              seen_ff, seen_in;
   logic              run_ff, run_in;
   logic [31:0]       base_ff, base_in;
   logic [31:0]       last_ff, last_in;
   logic signed [8:0] first_pct_ff, first_pct_in;
   logic [31:0]       first_el_ff, first_el_in;
   logic signed [8:0] latest_pct_ff, latest_pct_in;
   logic [31:0]       latest_el_ff, latest_el_in;
   logic [HEAD_W-1:0] head_ff, head_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              win_write;
   logic [3:0]        phase_ff, phase_in;

   logic [7:0]        win_pct_mem [RATE_WINDOW];
   logic [31:0]       win_el_mem  [RATE_WINDOW];
   logic [7:0]        rd_new_pct_ff, rd_old_pct_ff;
   logic [31:0]       rd_new_el_ff, rd_old_el_ff;
   logic [HEAD_W-1:0] newest_idx, oldest_idx;
   logic [FILL_W:0]   oldest_sum;

   logic              eta_ok_ff;
   logic [31:0]       eta_ff;
   logic [31:0]       dt_ff;
   logic [6:0]        rem_ff;
   logic [7:0]        dpct_ff;

   logic              rsp_valid_ff;
   logic [3:0]        rsp_phase_ff;
   logic              rsp_run_ff;
   logic              rsp_eta_valid_ff;
   logic [31:0]       rsp_eta_ff;

   logic signed [8:0]  pct9;
   logic               pct_restart, pct_advance;
   logic               stale;
   logic signed [9:0]  dpct_w;
   logic signed [33:0] dt_w;
   logic signed [9:0]  rem_w;
   logic               diff_bad, rem_none;
   logic               load_out;

   // ---------------- state update for one item ----------------
   assign pct9  = $signed({1'b0, item_ff.pct});
   assign stale = ((item_ff.now - last_ff) > timeout_ff);

   always_comb begin
      seen_in       = seen_ff;
      run_in        = run_ff;
      base_in       = base_ff;
      last_in       = last_ff;
      first_pct_in  = first_pct_ff;
      first_el_in   = first_el_ff;
      latest_pct_in = latest_pct_ff;
      latest_el_in  = latest_el_ff;
      head_in       = head_ff;
      fill_in       = fill_ff;
      win_write     = 1'b0;
      phase_in      = item_ff.phase;
      pct_restart   = first_pct_ff[8] || (pct9 < latest_pct_ff);
      pct_advance   = !pct_restart && (pct9 > latest_pct_ff);

      if (item_ff.kind == KIND_FREEZE) begin
         if (pct_restart) begin
            first_pct_in  = pct9;
            first_el_in   = item_ff.elapsed;
            latest_pct_in = pct9;
            latest_el_in  = item_ff.elapsed;
         end else if (pct_advance) begin
            latest_pct_in = pct9;
            latest_el_in  = item_ff.elapsed;
            win_write     = 1'b1;
            head_in       = (head_ff == HEAD_LAST) ? '0 : head_ff + 1'b1;
            if (fill_ff < FILL_MAX) begin
               fill_in = fill_ff + 1'b1;
            end
         end
      end

      if (item_ff.kind == KIND_TICK) begin
         if (seen_ff && run_ff && stale) begin
            run_in = 1'b0;
         end
      end else if (item_ff.kind == KIND_PREP) begin
         seen_in = 1'b1;
      end else if (item_ff.kind == KIND_PURGE || !seen_ff) begin
         seen_in = 1'b1;
         base_in = item_ff.elapsed;
         last_in = item_ff.now;
         run_in  = 1'b0;
      end else if (item_ff.elapsed > base_ff) begin
         base_in = item_ff.elapsed;
         last_in = item_ff.now;
         run_in  = 1'b1;
      end else if (item_ff.elapsed < base_ff) begin
         // fresh baseline: time since change is zero, never stale
         base_in = item_ff.elapsed;
         last_in = item_ff.now;
      end else if (stale) begin
         run_in = 1'b0;
      end

      if (item_ff.kind == KIND_IDLE_SCREEN) begin
         phase_in = run_in ? PH_RUNNING : PH_IDLE;
      end
   end

   // ---------------- window addressing ----------------
   assign newest_idx = (head_ff == '0) ? HEAD_LAST : head_ff - 1'b1;
   always_comb begin
      oldest_sum = (FILL_W + 1)'(head_ff) + WIN_EXT - {1'b0, fill_ff};
      if (oldest_sum >= WIN_EXT) begin
         oldest_sum = oldest_sum - WIN_EXT;
      end
   end
   assign oldest_idx = oldest_sum[HEAD_W-1:0];

   // ---------------- rate differences ----------------
   always_comb begin
      if (fill_ff >= FILL_TWO) begin
         dpct_w = $signed({2'b00, rd_new_pct_ff}) - $signed({2'b00, rd_old_pct_ff});
         dt_w   = $signed({2'b00, rd_new_el_ff}) - $signed({2'b00, rd_old_el_ff});
      end else begin
         dpct_w = {latest_pct_ff[8], latest_pct_ff} - {first_pct_ff[8], first_pct_ff};
         dt_w   = $signed({2'b00, latest_el_ff}) - $signed({2'b00, first_el_ff});
      end
      rem_w    = 10'sd100 - {latest_pct_ff[8], latest_pct_ff};
      diff_bad = (latest_pct_ff <= first_pct_ff) || (dpct_w <= 10'sd0) || (dt_w <= 34'sd0);
      rem_none = (rem_w <= 10'sd0);
   end

   // ---------------- sequencer ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in         = state_ff;
      pop              = 1'b0;
      load_out         = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = DIV_DIVIDEND_W'(dt_ff) * DIV_DIVIDEND_W'(rem_ff);
      div_req.divisor  = dpct_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               pop      = 1'b1;
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (item_ff.kind == KIND_FREEZE && item_ff.pct < PCT_FULL) begin
               state_in = ST_READ;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_READ: state_in = ST_DIFF;
         ST_DIFF: begin
            state_in = (diff_bad || rem_none) ? ST_OUT : ST_MUL;
         end
         ST_MUL: begin
            div_req.start = 1'b1;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------- control state ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff    <= STALE_RESET;
         seen_ff       <= 1'b0;
         run_ff        <= 1'b0;
         base_ff       <= '0;
         last_ff       <= '0;
         first_pct_ff  <= -9'sd1;
         first_el_ff   <= '0;
         latest_pct_ff <= -9'sd1;
         latest_el_ff  <= '0;
         head_ff       <= '0;
         fill_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            timeout_ff <= csr_wr_data;
         end
         if (state_ff == ST_UPDATE) begin
            seen_ff       <= seen_in;
            run_ff        <= run_in;
            base_ff       <= base_in;
            last_ff       <= last_in;
            first_pct_ff  <= first_pct_in;
            first_el_ff   <= first_el_in;
            latest_pct_ff <= latest_pct_in;
            latest_el_ff  <= latest_el_in;
            head_ff       <= head_in;
            fill_ff       <= fill_in;
         end
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // ---------------- window memory ----------------
   always_ff @(posedge clock) begin
      if (state_ff == ST_UPDATE && win_write) begin
         win_pct_mem[head_ff] <= item_ff.pct;
         win_el_mem[head_ff]  <= item_ff.elapsed;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_READ) begin
         rd_new_pct_ff <= win_pct_mem[newest_idx];
         rd_old_pct_ff <= win_pct_mem[oldest_idx];
         rd_new_el_ff  <= win_el_mem[newest_idx];
         rd_old_el_ff  <= win_el_mem[oldest_idx];
      end
   end

   // ---------------- payload ----------------
   always_ff @(posedge clock) begin
      if (pop) begin
         item_ff <= pop_item;
      end
      case (state_ff)
         ST_UPDATE: begin
            phase_ff  <= phase_in;
            eta_ok_ff <= (item_ff.kind == KIND_FREEZE) && (item_ff.pct >= PCT_FULL);
            eta_ff    <= '0;
         end
         ST_DIFF: begin
            eta_ok_ff <= !diff_bad;
            dt_ff     <= dt_w[31:0];
            rem_ff    <= rem_w[6:0];
            dpct_ff   <= dpct_w[7:0];
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               eta_ff <= (div_rsp.quotient[DIV_DIVIDEND_W-1:32] != '0) ? '1
                                                                      : div_rsp.quotient[31:0];
            end
         end
         default: begin
         end
      endcase
      if (load_out) begin
         rsp_phase_ff     <= phase_ff;
         rsp_run_ff       <= run_ff;
         rsp_eta_valid_ff <= eta_ok_ff;
         rsp_eta_ff       <= eta_ok_ff ? eta_ff : '0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_phase_code = rsp_phase_ff;
   assign rsp_run_active = rsp_run_ff;
   assign rsp_eta_valid  = rsp_eta_valid_ff;
   assign rsp_eta_s      = rsp_eta_ff;

endmodule

`default_nettype wire

>>> design/bpt_checker.sv
// Port-level checks on the result channel, bound to the top level.
`default_nettype none

module bpt_checker (
   input wire        clock,
   input wire        reset,
   input wire        rsp_valid,
   input wire        rsp_stall,
   input wire [3:0]  rsp_phase_code,
   input wire [0:0]  rsp_run_active,
   input wire [0:0]  rsp_eta_valid,
   input wire [31:0] rsp_eta_s
);
   import bpt_pkg::*;

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result item dropped while stalled");

   a_hold_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_phase_code) && $stable(rsp_run_active)
                                 && $stable(rsp_eta_valid) && $stable(rsp_eta_s))
      else $error("stalled result item changed");

   a_eta_freeze_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_eta_valid |-> rsp_phase_code == PH_FREEZE)
      else $error("estimate on a non-freeze item");

   a_no_eta_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_eta_valid |-> rsp_eta_s == 32'd0)
      else $error("estimate value without estimate");

   a_running_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_phase_code == PH_RUNNING |-> rsp_run_active)
      else $error("running phase without run flag");

endmodule

bind batch_phase_tracker_with_eta_top bpt_checker u_checker (.*);

`default_nettype wire

>>> bench/tb_batch_phase_tracker_with_eta_top.sv
// Self-checking testbench for the batch phase tracker: directed frames, then random batches.
import bpt_pkg::*;

typedef struct packed {
   logic [3:0]  phase;
   logic        run;
   logic        eta_ok;
   logic [31:0] eta;
} eta_status_type;

// Keeps its own copy of the tracker state and predicts one status per item.
// The window depth is 8, the default of the block.
class tracker_scoreboard;
   bit [31:0]      stale_ms;
   int             errors;
   bit             seen;
   bit             running;
   bit [31:0]      base_el;
   bit [31:0]      last_change;
   int             first_pct;
   int             latest_pct;
   bit [31:0]      first_el;
   bit [31:0]      latest_el;
   bit [7:0]       win_pct [8];
   bit [31:0]      win_el [8];
   bit [2:0]       head;
   bit [3:0]       fill;
   eta_status_type expected_status [$];

   function new();
      stale_ms   = STALE_RESET;
      first_pct  = -1;
      latest_pct = -1;
   endfunction

   function int pending();
      return expected_status.size();
   endfunction

   function void advance_freeze(bit [7:0] pct, bit [31:0] el);
      if (first_pct < 0 || int'(pct) < latest_pct) begin
         // restart of the freeze; the window keeps its entries
         first_pct  = int'(pct);
         first_el   = el;
         latest_pct = int'(pct);
         latest_el  = el;
      end else if (int'(pct) > latest_pct) begin
         latest_pct   = int'(pct);
         latest_el    = el;
         win_pct[head] = pct;
         win_el[head]  = el;
         head = head + 3'd1;
         if (fill < 4'd8)
            fill = fill + 4'd1;
      end
   endfunction

   function bit estimate_eta(bit [7:0] pct, output bit [31:0] eta);
      longint dpct, dt, rem, q, t_new, t_old;
      bit [2:0] newest, oldest;
      eta = '0;
      if (pct >= PCT_FULL)
         return 1'b1;
      if (first_pct < 0 || latest_pct <= first_pct)
         return 1'b0;
      if (fill >= 4'd2) begin
         newest = head - 3'd1;
         oldest = head - fill[2:0];
         dpct   = longint'(win_pct[newest]) - longint'(win_pct[oldest]);
         t_new  = longint'(win_el[newest]);
         t_old  = longint'(win_el[oldest]);
      end else begin
         dpct  = longint'(latest_pct) - longint'(first_pct);
         t_new = longint'(latest_el);
         t_old = longint'(first_el);
      end
      dt = t_new - t_old;
      if (dpct <= 0 || dt <= 0)
         return 1'b0;
      rem = longint'(100) - longint'(latest_pct);
      if (rem <= 0)
         return 1'b1;
      q   = (dt * rem) / dpct;
      eta = (q > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
      return 1'b1;
   endfunction

   function bit [3:0] phase_of(bit [7:0] ftype);
      case (ftype)
         FT_PREP:       return PH_PREP;
         FT_FREEZE:     return PH_FREEZE;
         FT_DRY:        return PH_DRY;
         FT_FINAL,
         FT_FINAL_ALT:  return PH_FINAL;
         FT_DONE:       return PH_DONE;
         FT_PURGE:      return PH_PURGE;
         FT_DEFROST:    return PH_DEFROST;
         FT_DEFROST_DN: return PH_DEFROST_DN;
         FT_TRANSITION: return PH_TRANSITION;
         FT_DIAG:       return PH_DIAG;
         FT_RECIPE:     return PH_RECIPE;
         FT_IDLE:       return running ? PH_RUNNING : PH_IDLE;
         default:       return PH_UNKNOWN;
      endcase
   endfunction

   function void update_run(bit [7:0] ftype, bit [31:0] el, bit [31:0] now);
      if (ftype == FT_PREP) begin
         seen = 1'b1;
      end else if (ftype == FT_PURGE || !seen) begin
         seen        = 1'b1;
         base_el     = el;
         last_change = now;
         running     = 1'b0;
      end else if (el > base_el) begin
         base_el     = el;
         last_change = now;
         running     = 1'b1;
      end else begin
         if (el < base_el) begin
            base_el     = el;
            last_change = now;
         end
         if ((now - last_change) > stale_ms)
            running = 1'b0;
      end
   endfunction

   function void note_frame(bit [0:0] cmd, bit [7:0] ftype, bit [31:0] el,
                            bit [7:0] pct, bit [31:0] now);
      eta_status_type s;
      s = '0;
      if (cmd == CMD_TICK) begin
         if (seen && running && (now - last_change) > stale_ms)
            running = 1'b0;
      end else begin
         if (ftype == FT_FREEZE)
            advance_freeze(pct, el);
         update_run(ftype, el, now);
         s.phase = phase_of(ftype);
         if (ftype == FT_FREEZE)
            s.eta_ok = estimate_eta(pct, s.eta);
         if (!s.eta_ok)
            s.eta = '0;
      end
      s.run = running;
      expected_status.push_back(s);
   endfunction

   task report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("%0t mismatch on %s: got %0h, expected %0h", $time, field, got, want);
   endtask

   task check_status(logic [3:0] phase, logic run, logic eta_ok, logic [31:0] eta);
      eta_status_type want;
      if (expected_status.size() == 0) begin
         report_mismatch("unexpected status item", 32'({phase, run, eta_ok}), '0);
         return;
      end
      want = expected_status.pop_front();
      if (phase !== want.phase)
         report_mismatch("phase_code", 32'(phase), 32'(want.phase));
      if (run !== want.run)
         report_mismatch("run_active", 32'(run), 32'(want.run));
      if (eta_ok !== want.eta_ok)
         report_mismatch("eta_valid", 32'(eta_ok), 32'(want.eta_ok));
      if (eta !== want.eta)
         report_mismatch("eta_s", eta, want.eta);
   endtask
endclass

module tb_batch_phase_tracker_with_eta_top;

   localparam logic [0:0] CMD_FRAME = 1'b0;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [0:0]  req_command = '0;
   logic [7:0]  req_frame_type = '0;
   logic [31:0] req_batch_elapsed_s = '0;
   logic [7:0]  req_progress_pct = '0;
   logic [31:0] req_now_ms = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [3:0]  rsp_phase_code;
   logic [0:0]  rsp_run_active;
   logic [0:0]  rsp_eta_valid;
   logic [31:0] rsp_eta_s;
   logic        csr_wr_en = 1'b0;
   logic [31:0] csr_wr_data = '0;

   tracker_scoreboard sb;

   // Idle ceilings for each side, redrawn every stretch of items so that both
   // busy and gappy traffic show up (0 means back to back).
   int send_gap_max   = 3;
   int recv_stall_max = 3;

   // Running state of the random batch generator: wall clock, batch counter,
   // freeze percent.
   bit [31:0] g_now;
   bit [31:0] g_el;
   bit [7:0]  g_pct;

   batch_phase_tracker_with_eta_top dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_command         (req_command),
      .req_frame_type      (req_frame_type),
      .req_batch_elapsed_s (req_batch_elapsed_s),
      .req_progress_pct    (req_progress_pct),
      .req_now_ms          (req_now_ms),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_phase_code      (rsp_phase_code),
      .rsp_run_active      (rsp_run_active),
      .rsp_eta_valid       (rsp_eta_valid),
      .rsp_eta_s           (rsp_eta_s),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Hard stop in case the block hangs or drops a status item.
   initial begin
      #8_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // Offer one item after a random gap; inputs move on the falling edge, the
   // handshake is sampled on the rising edge. Valid stays up after the accept
   // so a back-to-back item needs no bubble.
   task automatic send_frame(bit [0:0] cmd, bit [7:0] ftype, bit [31:0] el,
                             bit [7:0] pct, bit [31:0] now);
      int gap;
      gap = $urandom_range(0, send_gap_max);
      repeat (gap) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
      @(negedge clock);
      req_command         = cmd;
      req_frame_type      = ftype;
      req_batch_elapsed_s = el;
      req_progress_pct    = pct;
      req_now_ms          = now;
      req_valid           = 1'b1;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.note_frame(cmd, ftype, el, pct, now);
   endtask

   // Hold the sender off until every predicted status has come back.
   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
   endtask

   // Only called with the block drained.
   task automatic write_stale_timeout(bit [31:0] value);
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      @(posedge clock);
      sb.stale_ms = value;
      @(negedge clock);
      csr_wr_en   = 1'b0;
      csr_wr_data = $urandom;
   endtask

   function automatic bit [7:0] pick_screen();
      case ($urandom_range(0, 8))
         0:       return FT_TRANSITION;
         1:       return FT_DRY;
         2:       return FT_FINAL;
         3:       return FT_FINAL_ALT;
         4:       return FT_DONE;
         5:       return FT_DEFROST;
         6:       return FT_DEFROST_DN;
         7:       return FT_DIAG;
         default: return FT_RECIPE;
      endcase
   endfunction

   // Mostly plausible batches: the clock moves forward in second-ish steps
   // with occasional long stalls and wraps, the counter mostly creeps up,
   // freeze percent climbs with the odd restart. A small share is pure noise.
   task automatic random_traffic(int count);
      int        r;
      bit [7:0]  ftype;
      for (int i = 0; i < count; i++) begin
         if (i % 50 == 0) begin
            send_gap_max   = ($urandom_range(0, 2) == 0) ? 0 : 6;
            recv_stall_max = ($urandom_range(0, 2) == 0) ? 0 : 6;
         end

         r = $urandom_range(0, 99);
         if (r < 70)
            g_now += $urandom_range(200, 2500);
         else if (r < 97 && r >= 82)
            g_now += $urandom_range(1000, 150000);
         else if (r >= 97)
            g_now += $urandom;

         r = $urandom_range(0, 99);
         if (r < 6) begin
            send_frame(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), $urandom,
                       8'($urandom_range(0, 255)), $urandom);
         end else if (r < 18) begin
            send_frame(CMD_TICK, 8'($urandom_range(0, 255)), $urandom,
                       8'($urandom_range(0, 255)), g_now);
         end else begin
            r = $urandom_range(0, 99);
            if (r < 55)
               g_el += $urandom_range(1, 3);
            else if (r >= 85 && r < 93)
               g_el -= $urandom_range(1, 40);
            else if (r >= 93 && r < 97)
               g_el = $urandom_range(0, 1000);
            else if (r >= 97)
               g_el = $urandom;

            r = $urandom_range(0, 99);
            if (r < 40)
               ftype = FT_FREEZE;
            else if (r < 58)
               ftype = FT_IDLE;
            else if (r < 63)
               ftype = FT_PURGE;
            else if (r < 68)
               ftype = FT_PREP;
            else if (r < 96)
               ftype = pick_screen();
            else
               ftype = 8'($urandom_range(0, 255));

            if (ftype == FT_FREEZE) begin
               r = $urandom_range(0, 99);
               if (g_pct >= PCT_FULL && r < 50)
                  g_pct = 8'($urandom_range(0, 40));
               else if (r < 80)
                  g_pct = g_pct + 8'($urandom_range(0, 4));
               else if (r < 92)
                  g_pct = 8'($urandom_range(0, g_pct));
               else
                  g_pct = 8'($urandom_range(100, 255));
            end
            send_frame(CMD_FRAME, ftype, g_el, g_pct, g_now);
         end
      end
   endtask

   // Result side: draw a stall per item, then take whatever status shows up.
   initial begin : status_sink
      int hold;
      wait (reset === 1'b0);
      forever begin
         hold = $urandom_range(0, recv_stall_max);
         repeat (hold) begin
            @(negedge clock);
            rsp_stall = 1'b1;
         end
         @(negedge clock);
         rsp_stall = 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         sb.check_status(rsp_phase_code, rsp_run_active, rsp_eta_valid, rsp_eta_s);
      end
   end

   initial begin : stimulus
      bit [31:0] timeouts [6];
      sb = new();
      timeouts = '{32'd0, 32'hFFFF_FFFF, 32'd1500, 32'd7000, $urandom, STALE_RESET};

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part, stale timeout still at its reset value.
      // Tick before any frame: nothing to clear.
      send_frame(CMD_TICK, 8'd0, 32'd0, 8'd0, 32'd500);
      // First frame only takes the baseline, the next advance starts a run.
      send_frame(CMD_FRAME, FT_IDLE, 32'd100, 8'd0, 32'd1000);
      send_frame(CMD_FRAME, FT_IDLE, 32'd101, 8'd0, 32'd2000);
      // Prep frame leaves the run state alone even with a lower counter.
      send_frame(CMD_FRAME, FT_PREP, 32'd7, 8'd0, 32'd2500);
      send_frame(CMD_FRAME, FT_TRANSITION, 32'd102, 8'd0, 32'd3000);
      // Freeze: first percent, repeated percent (no estimate yet).
      send_frame(CMD_FRAME, FT_FREEZE, 32'd103, 8'd0, 32'd4000);
      send_frame(CMD_FRAME, FT_FREEZE, 32'd104, 8'd0, 32'd5000);
      // Huge time span over one percent: estimate saturates.
      send_frame(CMD_FRAME, FT_FREEZE, 32'hFFFF_FFFF, 8'd1, 32'd6000);
      // Counter jumps back; window sees a negative time difference.
      send_frame(CMD_FRAME, FT_FREEZE, 32'd10, 8'd20, 32'd7000);
      // Percent at and far above full.
      send_frame(CMD_FRAME, FT_FREEZE, 32'd20, 8'd100, 32'd8000);
      send_frame(CMD_FRAME, FT_FREEZE, 32'd30, 8'd255, 32'd9000);
      // Percent going backwards restarts freeze tracking.
      send_frame(CMD_FRAME, FT_FREEZE, 32'd40, 8'd3, 32'd10000);
      // Remaining screens, one unlisted type and the widest type value.
      send_frame(CMD_FRAME, FT_DRY, 32'd41, 8'd0, 32'd11000);
      send_frame(CMD_FRAME, FT_FINAL, 32'd42, 8'd0, 32'd11500);
      send_frame(CMD_FRAME, FT_FINAL_ALT, 32'd43, 8'd0, 32'd12000);
      send_frame(CMD_FRAME, FT_DONE, 32'd44, 8'd0, 32'd12500);
      send_frame(CMD_FRAME, FT_DEFROST, 32'd45, 8'd0, 32'd13000);
      send_frame(CMD_FRAME, FT_DEFROST_DN, 32'd46, 8'd0, 32'd13500);
      send_frame(CMD_FRAME, FT_DIAG, 32'd47, 8'd0, 32'd14000);
      send_frame(CMD_FRAME, FT_RECIPE, 32'd48, 8'd0, 32'd14500);
      send_frame(CMD_FRAME, 8'd0, 32'd49, 8'd0, 32'd15000);
      send_frame(CMD_FRAME, 8'd255, 32'd50, 8'd255, 32'd15500);
      // Counter stalls past the timeout: a tick drops the run, an idle frame
      // with the same counter then shows idle.
      send_frame(CMD_TICK, 8'd0, 32'd0, 8'd0, 32'd80000);
      send_frame(CMD_FRAME, FT_IDLE, 32'd50, 8'd0, 32'd81000);
      // Purge re-baselines near the top of the ms range, then the clock wraps.
      send_frame(CMD_FRAME, FT_PURGE, 32'd9, 8'd0, 32'hFFFF_FF00);
      send_frame(CMD_FRAME, FT_IDLE, 32'd10, 8'd0, 32'h0000_0100);
      // Tick with every field at its top value.
      send_frame(CMD_TICK, 8'd255, 32'hFFFF_FFFF, 8'd255, 32'hFFFF_FFFF);

      g_now = 32'h0000_0100;
      g_el  = 32'd10;
      g_pct = 8'd0;
      random_traffic(150);

      // Walk through timeout settings, extremes included; each change waits
      // for the block to go quiet.
      foreach (timeouts[k]) begin
         drain();
         write_stale_timeout(timeouts[k]);
         random_traffic(150);
      end

      drain();
      repeat (60) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
